@@ rtl/core/rlz_pkg.sv @@
// Shared types and constants for the packed-stream LZ decompressor.
`default_nettype none
package rlz_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_SKIP = 3'd2,
        PH_SIZE = 3'd3,
        PH_CMD  = 3'd4,
        PH_MORE = 3'd5,
        PH_LIT  = 3'd6
    } rlz_phase_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_COPY = 2'd1,
        ACT_STOP = 2'd2
    } rlz_act_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_TRUNC  = 2'd1,
        ST_BADREF = 2'd2
    } rlz_status_t;

    typedef enum logic [2:0] {
        CS_IDLE  = 3'd0,
        CS_PARSE = 3'd1,
        CS_COPYR = 3'd2,
        CS_COPYW = 3'd3,
        CS_FLUSH = 3'd4,
        CS_WAIT  = 3'd5
    } rlz_ctl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic parse;      // take held input word through the parser
        logic copy_rd;    // issue history read for the copy
        logic copy_wr;    // emit the read-back byte
        logic flush;      // load the output register from the pack buffer
        logic out_take;   // output register taken
    } rlz_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic copy_start; // parser left a copy to run
        logic copy_more;  // more copy bytes remain after this one
        logic pack_full;  // pack buffer holds a full result
        logic out_full;   // output register occupied and not being taken
    } rlz_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/rlz_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module rlz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/rlz_ctl.sv @@
// Controller state machine: sequences parse, copy, and result delivery.
`default_nettype none
module rlz_ctl
    import rlz_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire logic      out_stall,
    input  wire rlz_stat_t stat,
    output rlz_cmd_t       cmd
);

    rlz_ctl_state_t state_reg, state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_PARSE;
                end
            end
            CS_PARSE:
            begin
                state_next = stat.copy_start ? CS_COPYR : CS_FLUSH;
            end
            CS_COPYR:
            begin
                if (stat.pack_full)
                begin
                    state_next = CS_WAIT;
                end
                else
                begin
                    state_next = CS_COPYW;
                end
            end
            CS_COPYW:
            begin
                state_next = stat.copy_more ? CS_COPYR : CS_FLUSH;
            end
            CS_WAIT:
            begin
                if (!stat.out_full)
                begin
                    state_next = CS_COPYR;
                end
            end
            CS_FLUSH:
            begin
                if (!stat.out_full)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        in_stall     = 1'b1;
        cmd.out_take = !out_stall;
        unique case (state_reg)
            CS_IDLE:  in_stall = 1'b0;
            CS_PARSE: cmd.parse = 1'b1;
            CS_COPYR: cmd.copy_rd = !stat.pack_full;
            CS_COPYW: cmd.copy_wr = 1'b1;
            CS_WAIT:  cmd.flush = !stat.out_full;
            CS_FLUSH: cmd.flush = !stat.out_full;
            default:  in_stall = 1'b1;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_parse_outside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.parse |-> $past(state_reg) == CS_IDLE)
        else $error("parse outside accepted word");
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CS_COPYW |-> $past(cmd.copy_rd))
        else $error("copy write without read");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == CS_PARSE)
        else $error("accepted word not parsed");
`endif

endmodule
`default_nettype wire

@@ rtl/core/rlz_dp.sv @@
// Datapath: stream parser, history memory, pack buffer and output register.
`default_nettype none
module rlz_dp
    import rlz_pkg::*;
#(
    parameter int WINDOW_BYTES     = 131072,
    parameter int BYTES_PER_RESULT = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_in,
    input  wire rlz_cmd_t    cmd,
    output rlz_stat_t        stat,
    output logic             out_valid,
    output logic [63:0]      out_bytes_lo,
    output logic [63:0]      out_bytes_mid,
    output logic [63:0]      out_bytes_hi,
    output logic [4:0]       out_count,
    output logic             length_valid,
    output logic [31:0]      uncompressed_length,
    output logic [31:0]      consumed_count,
    output logic             stream_done,
    output logic [1:0]       status,
    output logic             last
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int CW = $clog2(BYTES_PER_RESULT + 1);
    localparam logic [AW:0] WIN_W = (AW+1)'(WINDOW_BYTES);

    // held input word
    logic [7:0]  byte_reg;
    logic        lst_reg;

    // parser state
    rlz_phase_t  phase_reg, phase_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] cmdb_reg, cmdb_next;
    logic [2:0]  have_reg, have_next;
    logic [2:0]  need_reg, need_next;
    logic [2:0]  hleft_reg, hleft_next;
    logic [6:0]  lits_reg, lits_next;
    rlz_act_t    act_reg, act_next;
    logic [17:0] pdist_reg, pdist_next;
    logic [10:0] plen_reg, plen_next;
    logic        fin_reg, fin_next;
    rlz_status_t st_reg, st_next;
    logic [31:0] cons_reg, cons_next;
    logic [31:0] prod_reg;
    logic [AW-1:0] wpos_reg;

    // copy engine
    logic [10:0] clen_reg, clen_next;
    logic [AW-1:0] cdist_reg, cdist_next;
    logic        go_copy;

    // literal emitted by the parse step, and history read data
    logic        lit_emit;
    logic [7:0]  rd_data;

    // pack buffer
    logic [7:0]  pack_reg [24];
    logic [CW-1:0] pcnt_reg;

    // output register
    logic        ov_reg;

    // parser combinational step
    always_comb
    begin
        logic [7:0]  f, s, t, u;
        logic [31:0] cb;
        logic [6:0]  lits;
        logic        complete;
        logic [7:0]  run;
        logic [31:0] ref_dist;
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        acc_next   = acc_reg;
        cmdb_next  = cmdb_reg;
        have_next  = have_reg;
        need_next  = need_reg;
        hleft_next = hleft_reg;
        lits_next  = lits_reg;
        act_next   = act_reg;
        pdist_next = pdist_reg;
        plen_next  = plen_reg;
        fin_next   = fin_reg;
        st_next    = st_reg;
        cons_next  = cons_reg;
        lit_emit   = 1'b0;
        go_copy    = 1'b0;
        complete   = 1'b0;
        cb         = cmdb_reg;
        lits       = '0;
        run        = '0;
        ref_dist   = '0;
        f          = '0;
        s          = '0;
        t          = '0;
        u          = '0;
        clen_next  = clen_reg;
        cdist_next = cdist_reg;
        if (!fin_reg)
        begin
            cons_next = cons_reg + 32'd1;
            case (phase_reg)
                PH_HDR0:
                begin
                    hdr_next   = {byte_reg, 8'd0};
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    hdr_next   = {hdr_reg[15:8], byte_reg};
                    acc_next   = '0;
                    hleft_next = hdr_reg[15] ? 3'd4 : 3'd3;
                    phase_next = hdr_reg[8] ? PH_SKIP : PH_SIZE;
                end
                PH_SKIP:
                begin
                    hleft_next = hleft_reg - 3'd1;
                    if (hleft_reg == 3'd1)
                    begin
                        hleft_next = hdr_reg[15] ? 3'd4 : 3'd3;
                        phase_next = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    acc_next   = {acc_reg[23:0], byte_reg};
                    hleft_next = hleft_reg - 3'd1;
                    if (hleft_reg == 3'd1)
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    cb        = {24'd0, byte_reg};
                    have_next = 3'd1;
                    if (!byte_reg[7])      need_next = 3'd2;
                    else if (!byte_reg[6]) need_next = 3'd3;
                    else if (!byte_reg[5]) need_next = 3'd4;
                    else                   need_next = 3'd1;
                    if (need_next == 3'd1) complete = 1'b1;
                    else                   phase_next = PH_MORE;
                end
                PH_MORE:
                begin
                    case (have_reg[1:0])
                        2'd1:    cb[15:8]  = byte_reg;
                        2'd2:    cb[23:16] = byte_reg;
                        2'd3:    cb[31:24] = byte_reg;
                        default: cb[7:0]   = cb[7:0] | byte_reg;
                    endcase
                    have_next = have_reg + 3'd1;
                    if (have_next >= need_reg) complete = 1'b1;
                end
                default:
                begin
                    lit_emit = 1'b1;
                    if (lits_reg != 7'd0) lits_next = lits_reg - 7'd1;
                    if (lits_next == 7'd0)
                    begin
                        phase_next = PH_CMD;
                        if (act_reg == ACT_COPY) go_copy = 1'b1;
                        else if (act_reg == ACT_STOP) fin_next = 1'b1;
                        act_next = ACT_NONE;
                    end
                end
            endcase
            cmdb_next = cb;
            // decode a finished command
            if (complete)
            begin
                f = cb[7:0]; s = cb[15:8]; t = cb[23:16]; u = cb[31:24];
                if (!f[7])
                begin
                    lits       = {5'd0, f[1:0]};
                    act_next   = ACT_COPY;
                    pdist_next = {8'd0, f[6:5], s} + 18'd1;
                    plen_next  = {8'd0, f[4:2]} + 11'd3;
                end
                else if (!f[6])
                begin
                    lits       = {5'd0, s[7:6]};
                    act_next   = ACT_COPY;
                    pdist_next = {4'd0, s[5:0], t} + 18'd1;
                    plen_next  = {5'd0, f[5:0]} + 11'd4;
                end
                else if (!f[5])
                begin
                    lits       = {5'd0, f[1:0]};
                    act_next   = ACT_COPY;
                    pdist_next = {1'b0, f[4], s, t} + 18'd1;
                    plen_next  = {1'b0, f[3:2], u} + 11'd5;
                end
                else
                begin
                    run = {1'b0, f[4:0], 2'b00} + 8'd4;
                    if (run <= 8'd112)
                    begin
                        lits     = run[6:0];
                        act_next = ACT_NONE;
                    end
                    else
                    begin
                        lits     = {5'd0, f[1:0]};
                        act_next = ACT_STOP;
                    end
                end
                if (lits != 7'd0)
                begin
                    lits_next  = lits;
                    phase_next = PH_LIT;
                end
                else
                begin
                    phase_next = PH_CMD;
                    if (act_next == ACT_COPY) go_copy = 1'b1;
                    else if (act_next == ACT_STOP) fin_next = 1'b1;
                    act_next = ACT_NONE;
                end
            end
            // check the reference; produced count includes a literal this word
            if (go_copy)
            begin
                ref_dist = {14'd0, pdist_next};
                if ({1'b0, ref_dist} > ({1'b0, prod_reg} + {32'd0, lit_emit})
                    || ref_dist > 32'(WINDOW_BYTES))
                begin
                    go_copy  = 1'b0;
                    fin_next = 1'b1;
                    st_next  = ST_BADREF;
                end
                else
                begin
                    clen_next  = plen_next;
                    cdist_next = ref_dist[AW-1:0];
                end
            end
            if (!fin_next && lst_reg)
            begin
                fin_next = 1'b1;
                if (phase_next != PH_CMD) st_next = ST_TRUNC;
            end
        end
    end

    // history memory
    logic          h_we;
    logic [AW-1:0] h_waddr, h_raddr;
    logic [7:0]    h_wdata;
    assign h_we    = (cmd.parse && lit_emit && !fin_reg) || cmd.copy_wr;
    assign h_waddr = wpos_reg;
    assign h_wdata = cmd.copy_wr ? rd_data : byte_reg;
    // wrap the read address around the window
    assign h_raddr = (wpos_reg >= cdist_reg) ? wpos_reg - cdist_reg
                     : AW'({1'b0, wpos_reg} + WIN_W - {1'b0, cdist_reg});

    rlz_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (rd_data)
    );

    // capture the accepted word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= in_byte;
            lst_reg  <= last_in;
        end
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            hdr_reg   <= '0;
            acc_reg   <= '0;
            cmdb_reg  <= '0;
            have_reg  <= '0;
            need_reg  <= '0;
            hleft_reg <= '0;
            lits_reg  <= '0;
            act_reg   <= ACT_NONE;
            pdist_reg <= '0;
            plen_reg  <= '0;
            fin_reg   <= 1'b0;
            st_reg    <= ST_OK;
            cons_reg  <= '0;
            clen_reg  <= '0;
            cdist_reg <= '0;
        end
        else if (cmd.parse)
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            acc_reg   <= acc_next;
            cmdb_reg  <= cmdb_next;
            have_reg  <= have_next;
            need_reg  <= need_next;
            hleft_reg <= hleft_next;
            lits_reg  <= lits_next;
            act_reg   <= act_next;
            pdist_reg <= pdist_next;
            plen_reg  <= plen_next;
            fin_reg   <= fin_next;
            st_reg    <= st_next;
            cons_reg  <= cons_next;
            clen_reg  <= go_copy ? clen_next : 11'd0;
            cdist_reg <= cdist_next;
        end
        else if (cmd.copy_wr)
        begin
            clen_reg <= clen_reg - 11'd1;
        end
    end

    // write pointer and produced count advance on every emitted byte; the count saturates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            prod_reg <= '0;
        end
        else if (h_we)
        begin
            wpos_reg <= (wpos_reg == AW'(WINDOW_BYTES - 1)) ? '0 : wpos_reg + 1'b1;
            if (prod_reg != 32'hFFFF_FFFF) prod_reg <= prod_reg + 32'd1;
        end
    end

    // pack buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= '0;
        end
        else if (cmd.flush)
        begin
            pcnt_reg <= '0;
        end
        else if (h_we)
        begin
            pcnt_reg <= pcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            pack_reg[5'(pcnt_reg)] <= h_wdata;
        end
    end

    // output register
    logic ending;
    assign ending = !(stat.copy_more) && (clen_reg == 11'd0);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.flush)
        begin
            ov_reg <= 1'b1;
        end
        else if (cmd.out_take)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flush)
        begin
            for (int i = 0; i < 8; i++)
            begin
                out_bytes_lo[8*i +: 8]  <= (i < pcnt_reg) ? pack_reg[i] : 8'd0;
                out_bytes_mid[8*i +: 8] <= (i + 8 < pcnt_reg) ? pack_reg[i+8] : 8'd0;
                out_bytes_hi[8*i +: 8]  <= (i + 16 < pcnt_reg) ? pack_reg[i+16] : 8'd0;
            end
            out_count           <= 5'(pcnt_reg);
            length_valid        <= (phase_reg >= PH_CMD);
            uncompressed_length <= (phase_reg >= PH_CMD) ? acc_reg : 32'd0;
            consumed_count      <= cons_reg;
            stream_done         <= fin_reg;
            status              <= st_reg;
            last                <= ending;
        end
    end

    assign out_valid       = ov_reg;
    assign stat.copy_start = go_copy && !fin_reg;
    assign stat.copy_more  = clen_reg > 11'd1;
    assign stat.pack_full  = (pcnt_reg == CW'(BYTES_PER_RESULT));
    assign stat.out_full   = ov_reg && !cmd.out_take;

`ifndef NO_ASSERTIONS
    a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg <= CW'(BYTES_PER_RESULT))
        else $error("pack buffer overrun");
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pack_full |-> !h_we)
        else $error("write to full pack buffer");
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(fin_reg) |-> fin_reg)
        else $error("finished flag cleared");
`endif

endmodule
`default_nettype wire

@@ rtl/core/refpack_lz_decompressor_unit.sv @@
// Top level of the packed-stream LZ decompressor.
// Takes one compressed byte per accepted word and returns decoded bytes in results of up to
// BYTES_PER_RESULT bytes, each carrying header length, consumed count and status; the last
// result of a word has last set. A word is accepted, parsed and flushed, and each back-reference
// byte is one registered read and one write of the single history memory of WINDOW_BYTES
// entries; each result that fills up while a copy still has bytes to go is handed over before
// the copy goes on, and a stalled output adds its wait.
`default_nettype none
module refpack_lz_decompressor_unit
    import rlz_pkg::*;
#(
    parameter int WINDOW_BYTES     = 131072,
    parameter int BYTES_PER_RESULT = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      out_bytes_lo,
    output logic [63:0]      out_bytes_mid,
    output logic [63:0]      out_bytes_hi,
    output logic [4:0]       out_count,
    output logic             length_valid,
    output logic [31:0]      uncompressed_length,
    output logic [31:0]      consumed_count,
    output logic             stream_done,
    output logic [1:0]       status,
    output logic             last
);

    rlz_cmd_t  cmd;
    rlz_stat_t stat;

    rlz_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rlz_dp #(
        .WINDOW_BYTES     (WINDOW_BYTES),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_accept           (in_valid && !in_stall),
        .in_byte             (in_byte),
        .last_in             (last_in),
        .cmd                 (cmd),
        .stat                (stat),
        .out_valid           (out_valid),
        .out_bytes_lo        (out_bytes_lo),
        .out_bytes_mid       (out_bytes_mid),
        .out_bytes_hi        (out_bytes_hi),
        .out_count           (out_count),
        .length_valid        (length_valid),
        .uncompressed_length (uncompressed_length),
        .consumed_count      (consumed_count),
        .stream_done         (stream_done),
        .status              (status),
        .last                (last)
    );

endmodule
`default_nettype wire
